### rtl/uvs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared types, constants and the arctangent table of the UV sphere generator.
// ----------------------------------------------------------------------------
package uvs_pkg;

    localparam int DIV_STAGES   = 40;
    localparam int CORDIC_STEPS = 24;
    localparam int MATH_STAGES  = 3;
    localparam int SIDE_LAT     = DIV_STAGES + CORDIC_STEPS + 1 + MATH_STAGES;
    localparam int Q_DEPTH      = 4;
    localparam int Q_AW         = 2;

    localparam logic [7:0] REG_RADIUS  = 8'd0;
    localparam logic [7:0] REG_SECTORS = 8'd1;
    localparam logic [7:0] REG_STACKS  = 8'd2;

    localparam logic [15:0] RADIUS_RESET  = 16'd256;
    localparam logic [7:0]  SECTORS_RESET = 8'd36;
    localparam logic [7:0]  STACKS_RESET  = 8'd18;
    localparam logic [7:0]  SECTORS_MIN   = 8'd3;
    localparam logic [7:0]  STACKS_MIN    = 8'd2;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

    typedef struct packed {
        logic [15:0] vertex_number;
        logic [15:0] below_number;
        logic        upper_tri_valid;
        logic        lower_tri_valid;
        logic        in_range;
    } side_t;

    typedef struct packed {
        logic [7:0] stack_index;
        logic [7:0] sector_index;
        side_t      side;
    } item_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] k);
        logic [31:0] a;
        unique case (k)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051E;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2F;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2FA;
            5'd15:   a = 32'h0000517D;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A30;
            5'd19:   a = 32'h00000518;
            5'd20:   a = 32'h0000028C;
            5'd21:   a = 32'h00000146;
            5'd22:   a = 32'h000000A3;
            5'd23:   a = 32'h00000051;
            default: a = 32'h00000000;
        endcase
        return a;
    endfunction

endpackage
`default_nettype wire

### rtl/uvs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_front
// Input stage: range check, vertex/below numbers and triangle flags.
// ----------------------------------------------------------------------------
module uvs_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    stack_index,
    input  wire logic [7:0]    sector_index,
    input  wire logic [7:0]    sec,
    input  wire logic [7:0]    stk,
    input  wire logic          q_full,
    output logic               push,
    output uvs_pkg::item_t     item
);
    import uvs_pkg::*;

    logic        valid_reg;
    item_t       item_reg;
    item_t       item_next;
    logic [17:0] k1_wide;
    logic        fits;
    logic        up;
    logic        lo;
    logic        load;

    assign in_stall = valid_reg && q_full;
    assign push     = valid_reg && !q_full;
    assign load     = !valid_reg || !q_full;
    assign item     = item_reg;

    always_comb
    begin
        fits    = (stack_index <= stk) && (sector_index <= sec);
        k1_wide = 18'(stack_index) * 18'({1'b0, sec} + 9'd1) + 18'(sector_index);
        up      = (stack_index < stk) && (sector_index < sec) && (stack_index != 8'd0);
        lo      = (stack_index < stk) && (sector_index < sec) && (stack_index != stk - 8'd1);
        item_next.stack_index  = stack_index;
        item_next.sector_index = sector_index;
        item_next.side.in_range        = fits;
        item_next.side.upper_tri_valid = fits && up;
        item_next.side.lower_tri_valid = fits && lo;
        item_next.side.vertex_number   = fits ? k1_wide[15:0] : 16'd0;
        item_next.side.below_number    = (fits && (up || lo))
                                         ? 16'(k1_wide[15:0] + {8'd0, sec} + 16'd1) : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule
`default_nettype wire

### rtl/uvs_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module uvs_queue
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  uvs_pkg::item_t     push_item,
    input  wire logic          pop,
    output logic               full,
    output logic               empty,
    output uvs_pkg::item_t     head
);
    import uvs_pkg::*;

    item_t            mem_reg [0:Q_DEPTH-1];
    logic [Q_AW-1:0]  wr_ptr_reg;
    logic [Q_AW-1:0]  rd_ptr_reg;
    logic [Q_AW:0]    count_reg;
    logic             do_pop;

    assign full   = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty  = (count_reg == '0);
    assign head   = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

### rtl/uvs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_div
// Pipelined restoring divider, 40-bit dividend by 8-bit divisor, one
// quotient bit per stage. Returns the low 32 quotient bits.
// ----------------------------------------------------------------------------
module uvs_div
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [39:0] dividend,
    input  wire logic [7:0]  divisor,
    output logic [31:0]      quotient
);
    import uvs_pkg::*;

    logic [7:0]  rem_reg  [0:DIV_STAGES-1];
    logic [39:0] num_reg  [0:DIV_STAGES-1];
    logic [31:0] q_reg    [0:DIV_STAGES-1];
    logic [7:0]  rem_next [0:DIV_STAGES-1];
    logic [39:0] num_next [0:DIV_STAGES-1];
    logic [31:0] q_next   [0:DIV_STAGES-1];

    assign quotient = q_reg[DIV_STAGES-1];

    always_comb
    begin
        logic [7:0]  r;
        logic [39:0] n;
        logic [31:0] q;
        logic [8:0]  t;
        logic        ge;
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                r = '0;
                n = dividend;
                q = '0;
            end
            else
            begin
                r = rem_reg[k-1];
                n = num_reg[k-1];
                q = q_reg[k-1];
            end
            t           = {r, n[39]};
            ge          = (t >= {1'b0, divisor});
            rem_next[k] = ge ? 8'(t - {1'b0, divisor}) : t[7:0];
            num_next[k] = {n[38:0], 1'b0};
            q_next[k]   = {q[30:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                num_reg[k] <= num_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

endmodule
`default_nettype wire

### rtl/uvs_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation CORDIC on a binary angle: quadrant fold, 24 stages,
// then unfold and clamp to [-1, +1] in Q2.30.
// ----------------------------------------------------------------------------
module uvs_cordic
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] angle,
    output logic signed [31:0] cos_q30,
    output logic signed [31:0] sin_q30
);
    import uvs_pkg::*;

    logic signed [33:0] x_reg  [0:CORDIC_STEPS-1];
    logic signed [33:0] y_reg  [0:CORDIC_STEPS-1];
    logic signed [33:0] z_reg  [0:CORDIC_STEPS-1];
    logic               f_reg  [0:CORDIC_STEPS-1];
    logic signed [33:0] x_next [0:CORDIC_STEPS-1];
    logic signed [33:0] y_next [0:CORDIC_STEPS-1];
    logic signed [33:0] z_next [0:CORDIC_STEPS-1];
    logic               f_next [0:CORDIC_STEPS-1];
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] c_next;
    logic signed [31:0] s_next;

    assign cos_q30 = c_reg;
    assign sin_q30 = s_reg;

    always_comb
    begin
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
        logic               f;
        logic [31:0]        a;
        logic signed [33:0] at;
        for (int k = 0; k < CORDIC_STEPS; k++)
        begin
            if (k == 0)
            begin
                // fold quadrants 1 and 2 by a half turn
                f = angle[31] ^ angle[30];
                a = f ? {~angle[31], angle[30:0]} : angle;
                x = CORDIC_GAIN;
                y = '0;
                z = 34'($signed(a));
            end
            else
            begin
                x = x_reg[k-1];
                y = y_reg[k-1];
                z = z_reg[k-1];
                f = f_reg[k-1];
            end
            at = $signed({2'b00, atan_turn(5'(k))});
            if (!z[33])
            begin
                x_next[k] = x - (y >>> k);
                y_next[k] = y + (x >>> k);
                z_next[k] = z - at;
            end
            else
            begin
                x_next[k] = x + (y >>> k);
                y_next[k] = y - (x >>> k);
                z_next[k] = z + at;
            end
            f_next[k] = f;
        end
    end

    always_comb
    begin
        logic signed [33:0] xc;
        logic signed [33:0] yc;
        xc = f_reg[CORDIC_STEPS-1] ? -x_reg[CORDIC_STEPS-1] : x_reg[CORDIC_STEPS-1];
        yc = f_reg[CORDIC_STEPS-1] ? -y_reg[CORDIC_STEPS-1] : y_reg[CORDIC_STEPS-1];
        if (xc > ONE_Q30)
            c_next = 32'(ONE_Q30);
        else if (xc < -ONE_Q30)
            c_next = 32'(-ONE_Q30);
        else
            c_next = 32'(xc);
        if (yc > ONE_Q30)
            s_next = 32'(ONE_Q30);
        else if (yc < -ONE_Q30)
            s_next = 32'(-ONE_Q30);
        else
            s_next = 32'(yc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < CORDIC_STEPS; k++)
            begin
                x_reg[k] <= x_next[k];
                y_reg[k] <= y_next[k];
                z_reg[k] <= z_next[k];
                f_reg[k] <= f_next[k];
            end
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

endmodule
`default_nettype wire

### rtl/uvs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uvs_back
// Angle division, sine/cosine, scaling and output register. All stages
// advance together whenever the output register is free or being taken.
// ----------------------------------------------------------------------------
module uvs_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  uvs_pkg::item_t     q_head,
    output logic               q_pop,
    input  wire logic [15:0]   radius,
    input  wire logic [7:0]    sec,
    input  wire logic [7:0]    stk,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [15:0]        vertex_number,
    output logic [15:0]        below_number,
    output logic               upper_tri_valid,
    output logic               lower_tri_valid,
    output logic               in_range
);
    import uvs_pkg::*;

    function automatic logic signed [16:0] sat_pos(input logic signed [65:0] v);
        if (v > 66'sd65535)
            return 17'sd65535;
        else if (v < -66'sd65535)
            return -17'sd65535;
        else
            return 17'(v);
    endfunction

    function automatic logic signed [15:0] sat_norm(input logic signed [65:0] v);
        if (v > 66'sd32767)
            return 16'sd32767;
        else if (v < -66'sd32768)
            return -16'sd32768;
        else
            return 16'(v);
    endfunction

    logic               adv;
    logic [39:0]        stk_num;
    logic [39:0]        sec_num;
    logic [31:0]        stk_q;
    logic [31:0]        sec_q;
    logic [31:0]        stk_ang;
    logic signed [31:0] cs;
    logic signed [31:0] ss;
    logic signed [31:0] cj;
    logic signed [31:0] sj;

    logic  vld_reg  [0:SIDE_LAT-1];
    side_t side_reg [0:SIDE_LAT-1];

    // first math stage
    logic signed [48:0] prc_reg;
    logic signed [48:0] prs_reg;
    logic signed [63:0] pcc_reg;
    logic signed [63:0] pcs_reg;
    logic signed [15:0] nz1_reg;
    logic signed [31:0] cj1_reg;
    logic signed [31:0] sj1_reg;
    // second math stage
    logic signed [33:0] xy_reg;
    logic signed [16:0] pz2_reg;
    logic signed [15:0] nx2_reg;
    logic signed [15:0] ny2_reg;
    logic signed [15:0] nz2_reg;
    logic signed [31:0] cj2_reg;
    logic signed [31:0] sj2_reg;
    // third math stage
    logic signed [65:0] pxp_reg;
    logic signed [65:0] pyp_reg;
    logic signed [16:0] pz3_reg;
    logic signed [15:0] nx3_reg;
    logic signed [15:0] ny3_reg;
    logic signed [15:0] nz3_reg;
    // output register
    logic               out_valid_reg;
    logic signed [16:0] px_reg;
    logic signed [16:0] py_reg;
    logic signed [16:0] pz_reg;
    logic signed [15:0] nx_reg;
    logic signed [15:0] ny_reg;
    logic signed [15:0] nz_reg;
    side_t              oside_reg;

    logic signed [32:0] ss_rnd;
    logic signed [48:0] xy_rnd;
    logic signed [48:0] pz_rnd;
    logic signed [63:0] nx_rnd;
    logic signed [63:0] ny_rnd;
    logic signed [65:0] px_rnd;
    logic signed [65:0] py_rnd;
    side_t              last_side;

    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && !q_empty;

    // i * half turn + stk/2, and j * full turn + sec/2
    assign stk_num = {1'b0, q_head.stack_index, 24'd0, stk[7:1]};
    assign sec_num = {q_head.sector_index, 25'd0, sec[7:1]};

    uvs_div u_div_stk
    (
        .clk      (clk),
        .en       (adv),
        .dividend (stk_num),
        .divisor  (stk),
        .quotient (stk_q)
    );

    uvs_div u_div_sec
    (
        .clk      (clk),
        .en       (adv),
        .dividend (sec_num),
        .divisor  (sec),
        .quotient (sec_q)
    );

    assign stk_ang = 32'h40000000 - stk_q;

    uvs_cordic u_cordic_stk
    (
        .clk     (clk),
        .en      (adv),
        .angle   (stk_ang),
        .cos_q30 (cs),
        .sin_q30 (ss)
    );

    uvs_cordic u_cordic_sec
    (
        .clk     (clk),
        .en      (adv),
        .angle   (sec_q),
        .cos_q30 (cj),
        .sin_q30 (sj)
    );

    always_comb
    begin
        ss_rnd = (33'(ss) + 33'sd16384) >>> 15;
        xy_rnd = (prc_reg + 49'sd8192) >>> 14;
        pz_rnd = (prs_reg + 49'sd536870912) >>> 30;
        nx_rnd = (pcc_reg + 64'sd17592186044416) >>> 45;
        ny_rnd = (pcs_reg + 64'sd17592186044416) >>> 45;
        px_rnd = (pxp_reg + 66'sd35184372088832) >>> 46;
        py_rnd = (pyp_reg + 66'sd35184372088832) >>> 46;
        last_side = side_reg[SIDE_LAT-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIDE_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= !q_empty;
            for (int k = 1; k < SIDE_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_valid_reg <= vld_reg[SIDE_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= q_head.side;
            for (int k = 1; k < SIDE_LAT; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end

            prc_reg <= $signed({1'b0, radius}) * cs;
            prs_reg <= $signed({1'b0, radius}) * ss;
            pcc_reg <= cs * cj;
            pcs_reg <= cs * sj;
            nz1_reg <= sat_norm(66'(ss_rnd));
            cj1_reg <= cj;
            sj1_reg <= sj;

            xy_reg  <= 34'(xy_rnd);
            pz2_reg <= sat_pos(66'(pz_rnd));
            nx2_reg <= sat_norm(66'(nx_rnd));
            ny2_reg <= sat_norm(66'(ny_rnd));
            nz2_reg <= nz1_reg;
            cj2_reg <= cj1_reg;
            sj2_reg <= sj1_reg;

            pxp_reg <= xy_reg * cj2_reg;
            pyp_reg <= xy_reg * sj2_reg;
            pz3_reg <= pz2_reg;
            nx3_reg <= nx2_reg;
            ny3_reg <= ny2_reg;
            nz3_reg <= nz2_reg;

            // outside the grid every field but in_range reads zero
            px_reg    <= last_side.in_range ? sat_pos(px_rnd) : '0;
            py_reg    <= last_side.in_range ? sat_pos(py_rnd) : '0;
            pz_reg    <= last_side.in_range ? pz3_reg : '0;
            nx_reg    <= last_side.in_range ? nx3_reg : '0;
            ny_reg    <= last_side.in_range ? ny3_reg : '0;
            nz_reg    <= last_side.in_range ? nz3_reg : '0;
            oside_reg <= last_side;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pos_x           = px_reg;
    assign pos_y           = py_reg;
    assign pos_z           = pz_reg;
    assign norm_x          = nx_reg;
    assign norm_y          = ny_reg;
    assign norm_z          = nz_reg;
    assign vertex_number   = oside_reg.vertex_number;
    assign below_number    = oside_reg.below_number;
    assign upper_tri_valid = oside_reg.upper_tri_valid;
    assign lower_tri_valid = oside_reg.lower_tri_valid;
    assign in_range        = oside_reg.in_range;

endmodule
`default_nettype wire

### rtl/uv_sphere_vertex_and_index_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uv_sphere_vertex_and_index_generator_unit
// UV sphere grid point to vertex position, normal, indices and triangle flags.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | stack_index, sector_index
//  out     | out_valid / out_stall| pos_*, norm_*, vertex/below_number, flags
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One grid point per cycle sustained while out_stall is low. With no stall, an
// input passes the front register, the queue, 40 angle divider stages, 25 CORDIC
// stages, three math stages and the output register. Reset restores radius 1.0,
// 36 sectors, 18 stacks. An output stall with out_valid high freezes the back
// pipeline; the four-entry queue and the front register keep taking input until they fill.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_and_index_generator_unit
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    stack_index,
    input  wire logic [7:0]    sector_index,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic signed [16:0] pos_x,
    output logic signed [16:0] pos_y,
    output logic signed [16:0] pos_z,
    output logic signed [15:0] norm_x,
    output logic signed [15:0] norm_y,
    output logic signed [15:0] norm_z,
    output logic [15:0]        vertex_number,
    output logic [15:0]        below_number,
    output logic               upper_tri_valid,
    output logic               lower_tri_valid,
    output logic               in_range,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [7:0]    cfg_index,
    input  wire logic [15:0]   cfg_data
);
    import uvs_pkg::*;

    logic [15:0] radius_reg;
    logic [7:0]  sectors_reg;
    logic [7:0]  stacks_reg;
    logic [7:0]  sec;
    logic [7:0]  stk;
    logic        q_full;
    logic        q_empty;
    logic        push;
    logic        q_pop;
    item_t       front_item;
    item_t       q_head;

    assign cfg_ready = 1'b1;

    // counts below their minimum act as the minimum
    assign sec = (sectors_reg < SECTORS_MIN) ? SECTORS_MIN : sectors_reg;
    assign stk = (stacks_reg < STACKS_MIN) ? STACKS_MIN : stacks_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= RADIUS_RESET;
            sectors_reg <= SECTORS_RESET;
            stacks_reg  <= STACKS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_RADIUS:  radius_reg  <= cfg_data;
                REG_SECTORS: sectors_reg <= cfg_data[7:0];
                REG_STACKS:  stacks_reg  <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    uvs_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .stack_index  (stack_index),
        .sector_index (sector_index),
        .sec          (sec),
        .stk          (stk),
        .q_full       (q_full),
        .push         (push),
        .item         (front_item)
    );

    uvs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    uvs_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .radius          (radius_reg),
        .sec             (sec),
        .stk             (stk),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .norm_x          (norm_x),
        .norm_y          (norm_y),
        .norm_z          (norm_z),
        .vertex_number   (vertex_number),
        .below_number    (below_number),
        .upper_tri_valid (upper_tri_valid),
        .lower_tri_valid (lower_tri_valid),
        .in_range        (in_range)
    );

endmodule
`default_nettype wire
